@@ rtl/ede_pkg.sv @@
// ----------------------------------------------------------------------------
// ede_pkg
// Shared opcodes, controller command and status types, character folding.
// ----------------------------------------------------------------------------
package ede_pkg;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [6:0] DIST_MAX = 7'd127;

    // commands from controller to datapath
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic empty_done;
        logic init_wr;
        logic row_start;
        logic update;
        logic finish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_valid;
        logic a_empty;
        logic b_empty;
    } status_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && c inside {[8'h41:8'h5A]})
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ rtl/ede_ctrl.sv @@
// ----------------------------------------------------------------------------
// ede_ctrl
// Sequencer: takes requests, walks the rows and columns of the recurrence.
// ----------------------------------------------------------------------------
module ede_ctrl
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         op,
    input  logic                               out_stall,
    input  status_t                            sts,
    input  logic [$clog2(MAX_LEN + 1) - 1:0]   first_length,
    input  logic [$clog2(MAX_LEN + 1) - 1:0]   second_length,
    output cmd_t                               cmd,
    output logic [$clog2(MAX_LEN + 1) - 1:0]   row_idx,
    output logic [$clog2(MAX_LEN + 1) - 1:0]   col_idx
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INIT = 2'd1;
    localparam logic [1:0] S_ROW  = 2'd2;
    localparam logic [1:0] S_CELL = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] row_reg, row_next;
    logic [LEN_W-1:0] col_reg, col_next;
    logic             accept;

    // a compute request waits while the previous result is still held
    assign in_stall = (state_reg != S_IDLE) ||
                      ((op == OP_COMPUTE) && sts.out_valid && out_stall);
    assign accept   = in_valid && !in_stall;

    assign row_idx = row_reg;
    assign col_idx = col_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load_a = accept && (op == OP_LOAD_A);
                cmd.load_b = accept && (op == OP_LOAD_B);
                if (accept && (op == OP_COMPUTE))
                begin
                    if (sts.a_empty || sts.b_empty)
                    begin
                        cmd.empty_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_INIT;
                        col_next   = LEN_W'(1);
                    end
                end
            end
            S_INIT:
            begin
                cmd.init_wr = 1'b1;
                if (col_reg == second_length)
                begin
                    state_next = S_ROW;
                    row_next   = LEN_W'(1);
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_ROW:
            begin
                cmd.row_start = 1'b1;
                col_next      = LEN_W'(1);
                state_next    = S_CELL;
            end
            S_CELL:
            begin
                cmd.update = 1'b1;
                if (col_reg == second_length)
                begin
                    if (row_reg == first_length)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

endmodule

@@ rtl/ede_datapath.sv @@
// ----------------------------------------------------------------------------
// ede_datapath
// String stores, single row buffer, cell update and result register.
// ----------------------------------------------------------------------------
module ede_datapath
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_data,
    input  logic [7:0]                         character,
    input  cmd_t                               cmd,
    input  logic [$clog2(MAX_LEN + 1) - 1:0]   row_idx,
    input  logic [$clog2(MAX_LEN + 1) - 1:0]   col_idx,
    output status_t                            sts,
    output logic [$clog2(MAX_LEN + 1) - 1:0]   first_length,
    output logic [$clog2(MAX_LEN + 1) - 1:0]   second_length,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [6:0]                         distance,
    output logic                               truncated
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int WIDE_W = (LEN_W > 7) ? LEN_W : 7;

    logic [7:0]       a_mem [MAX_LEN];
    logic [7:0]       b_mem [MAX_LEN];
    logic [LEN_W-1:0] row_mem [MAX_LEN + 1];

    logic             case_sensitive_reg;
    logic [LEN_W-1:0] a_len_reg, b_len_reg;
    logic             overflow_reg;
    logic [7:0]       a_rd_reg, b_rd_reg;
    logic [LEN_W-1:0] r_rd_reg;
    logic [LEN_W-1:0] left_reg, diag_reg;
    logic             out_valid_reg;
    logic [6:0]       distance_reg;
    logic             truncated_reg;

    logic             a_full, b_full;
    logic             last_col;
    logic             rd_en;
    logic [IDX_W-1:0] a_addr, b_addr;
    logic [LEN_W-1:0] r_addr;
    logic [LEN_W-1:0] row_less;
    logic             sub;
    logic [LEN_W:0]   up_c, left_c, diag_c, min_ab, min_all;
    logic [LEN_W-1:0] cur;
    logic [LEN_W-1:0] dist_src;
    logic [WIDE_W-1:0] dist_wide;
    logic [6:0]       dist_sat;
    logic             done;

    assign cfg_ready = 1'b1;

    assign a_full   = (a_len_reg == LEN_W'(MAX_LEN));
    assign b_full   = (b_len_reg == LEN_W'(MAX_LEN));
    assign last_col = (col_idx == b_len_reg);

    // reads for the next column go out while the current one is computed
    assign rd_en    = cmd.row_start || (cmd.update && !last_col);
    assign row_less = row_idx - 1'b1;
    assign a_addr   = row_less[IDX_W-1:0];
    assign b_addr   = cmd.row_start ? '0 : col_idx[IDX_W-1:0];
    assign r_addr   = cmd.row_start ? LEN_W'(1) : col_idx + 1'b1;

    assign sub     = fold_char(a_rd_reg, case_sensitive_reg) !=
                     fold_char(b_rd_reg, case_sensitive_reg);
    assign up_c    = {1'b0, r_rd_reg} + 1'b1;
    assign left_c  = {1'b0, left_reg} + 1'b1;
    assign diag_c  = {1'b0, diag_reg} + {{LEN_W{1'b0}}, sub};
    assign min_ab  = (up_c < left_c) ? up_c : left_c;
    assign min_all = (min_ab < diag_c) ? min_ab : diag_c;
    assign cur     = min_all[LEN_W-1:0];

    assign done      = cmd.empty_done || cmd.finish;
    assign dist_src  = cmd.finish ? cur : (sts.a_empty ? b_len_reg : a_len_reg);
    assign dist_wide = WIDE_W'(dist_src);
    assign dist_sat  = (dist_wide > WIDE_W'(DIST_MAX)) ? DIST_MAX : dist_wide[6:0];

    assign sts.out_valid = out_valid_reg;
    assign sts.a_empty   = (a_len_reg == '0);
    assign sts.b_empty   = (b_len_reg == '0);

    assign first_length  = a_len_reg;
    assign second_length = b_len_reg;
    assign out_valid     = out_valid_reg;
    assign distance      = distance_reg;
    assign truncated     = truncated_reg;

    // string stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && !a_full)
        begin
            a_mem[a_len_reg[IDX_W-1:0]] <= character;
        end
        if (cmd.load_b && !b_full)
        begin
            b_mem[b_len_reg[IDX_W-1:0]] <= character;
        end
        if (cmd.row_start)
        begin
            a_rd_reg <= a_mem[a_addr];
        end
        if (rd_en)
        begin
            b_rd_reg <= b_mem[b_addr];
        end
    end

    // row buffer holds the previous row; each cell overwrites its own column
    always_ff @(posedge clk)
    begin
        if (cmd.init_wr)
        begin
            row_mem[col_idx] <= col_idx;
        end
        else if (cmd.update)
        begin
            row_mem[col_idx] <= cur;
        end
        if (rd_en)
        begin
            r_rd_reg <= row_mem[r_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            left_reg <= row_idx;
            diag_reg <= row_less;
        end
        else if (cmd.update)
        begin
            left_reg <= cur;
            diag_reg <= r_rd_reg;
        end
        if (done)
        begin
            distance_reg  <= dist_sat;
            truncated_reg <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_sensitive_reg <= 1'b1;
            a_len_reg          <= '0;
            b_len_reg          <= '0;
            overflow_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case_sensitive_reg <= cfg_data;
            end
            if (done)
            begin
                a_len_reg    <= '0;
                b_len_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (cmd.load_a)
                begin
                    if (a_full)
                        overflow_reg <= 1'b1;
                    else
                        a_len_reg <= a_len_reg + 1'b1;
                end
                if (cmd.load_b)
                begin
                    if (b_full)
                        overflow_reg <= 1'b1;
                    else
                        b_len_reg <= b_len_reg + 1'b1;
                end
            end
            if (done)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/edit_distance_engine.sv @@
// ----------------------------------------------------------------------------
// edit_distance_engine
// Levenshtein distance between two loaded strings, single row buffer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_stall    op, character
//   out      output     out_valid/out_stall  distance, truncated
//   cfg      input      cfg_valid/cfg_ready  cfg_data (case_sensitive)
//
// load requests are accepted while idle; a compute request with an empty
// string needs no cell loop; otherwise the input stalls while the initial row
// is written and the cell loop reads and writes the one row memory per column.
// the result register lets loads continue while a result waits to be taken.
// reset clears lengths, flags and control; the memories are not cleared.
// ----------------------------------------------------------------------------
module edit_distance_engine
    import ede_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] distance,
    output logic       truncated,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    cmd_t             cmd;
    status_t          sts;
    logic [LEN_W-1:0] row_idx, col_idx;
    logic [LEN_W-1:0] first_length, second_length;

    ede_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .out_stall     (out_stall),
        .sts           (sts),
        .first_length  (first_length),
        .second_length (second_length),
        .cmd           (cmd),
        .row_idx       (row_idx),
        .col_idx       (col_idx)
    );

    ede_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .character     (character),
        .cmd           (cmd),
        .row_idx       (row_idx),
        .col_idx       (col_idx),
        .sts           (sts),
        .first_length  (first_length),
        .second_length (second_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .distance      (distance),
        .truncated     (truncated)
    );

endmodule

@@ test/tb_edit_distance_engine.sv @@
// ----------------------------------------------------------------------------
// tb_edit_distance_engine
// Self-checking bench for the edit distance engine. Load and compute requests
// are driven through the stall handshake and folded into a local two-row
// Levenshtein predictor. Every result is compared with the oldest pending
// prediction. Random idling runs on both sides, with one long result hold-off
// and both case folding settings.
// ----------------------------------------------------------------------------
module tb_edit_distance_engine
    import ede_pkg::*;
();

    localparam int         MAX_LEN       = 64;
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         ITEM_TARGET   = 1950;
    localparam int         RAND_PHASES   = 6;

    typedef struct packed {
        logic [6:0] distance;
        logic       truncated;
    } distance_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [1:0] op        = OP_LOAD_A;
    logic [7:0] character = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] distance;
    logic       truncated;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    // predictor state
    logic [7:0]       str_a [MAX_LEN];
    logic [7:0]       str_b [MAX_LEN];
    int               len_a         = 0;
    int               len_b         = 0;
    logic             overflow_pred = 1'b0;
    logic             case_sens     = 1'b1;
    distance_result_t pending_distances [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int hold_request   = 0;
    bit no_idle        = 1'b0;

    always #5 clk = ~clk;

    edit_distance_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .character (character),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance),
        .truncated (truncated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (!case_sens && c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [6:0] predict_distance();
        int prev [MAX_LEN + 1];
        int cur [MAX_LEN + 1];
        int best;
        int sub;
        if (len_a == 0)
        begin
            return 7'(len_b);
        end
        if (len_b == 0)
        begin
            return 7'(len_a);
        end
        for (int j = 0; j <= len_b; j++)
        begin
            prev[j] = j;
        end
        for (int i = 1; i <= len_a; i++)
        begin
            cur[0] = i;
            for (int j = 1; j <= len_b; j++)
            begin
                sub  = (lower_ascii(str_a[i - 1]) == lower_ascii(str_b[j - 1])) ? 0 : 1;
                best = prev[j] + 1;
                if (cur[j - 1] + 1 < best)
                begin
                    best = cur[j - 1] + 1;
                end
                if (prev[j - 1] + sub < best)
                begin
                    best = prev[j - 1] + sub;
                end
                cur[j] = best;
            end
            prev = cur;
        end
        best = prev[len_b];
        if (best > 127)
        begin
            best = 127;
        end
        return 7'(best);
    endfunction

    task automatic apply_request(input logic [1:0] req_op, input logic [7:0] req_char);
        distance_result_t res;
        case (req_op)
            OP_LOAD_A:
            begin
                if (len_a < MAX_LEN)
                begin
                    str_a[len_a] = req_char;
                    len_a++;
                end
                else
                begin
                    overflow_pred = 1'b1;
                end
            end
            OP_LOAD_B:
            begin
                if (len_b < MAX_LEN)
                begin
                    str_b[len_b] = req_char;
                    len_b++;
                end
                else
                begin
                    overflow_pred = 1'b1;
                end
            end
            OP_COMPUTE:
            begin
                res.distance  = predict_distance();
                res.truncated = overflow_pred;
                pending_distances.push_back(res);
                len_a         = 0;
                len_b         = 0;
                overflow_pred = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic [1:0] req_op, input logic [7:0] req_char);
        if (!no_idle && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= req_op;
        character <= req_char;
        @(posedge clk);
        while (in_stall !== 1'b0)
        begin
            @(posedge clk);
        end
        apply_request(req_op, req_char);
        if (req_op != OP_UNUSED)
        begin
            items_sent++;
        end
        @(negedge clk);
    endtask

    task automatic wait_for_idle();
        in_valid <= 1'b0;
        while (pending_distances.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_case_mode(input logic value);
        wait_for_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
        begin
            @(posedge clk);
        end
        case_sens = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // narrow set mixes cases and the characters just outside A..Z / a..z
    function automatic logic [7:0] pick_char(input bit narrow);
        if (!narrow)
        begin
            return 8'($urandom);
        end
        case ($urandom_range(7))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            3: return 8'h42;
            4: return 8'h7A;
            5: return 8'h5A;
            6: return 8'h40;
            default: return 8'h60;
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 88)
        begin
            return $urandom_range(8);
        end
        if (r < 97)
        begin
            return $urandom_range(24, 9);
        end
        return $urandom_range(68, 40);
    endfunction

    task automatic send_string_pair(input int la, input int lb, input bit narrow);
        int left_a;
        int left_b;
        left_a = la;
        left_b = lb;
        while (left_a + left_b > 0)
        begin
            if ($urandom_range(99) < 4)
            begin
                send_request(OP_UNUSED, 8'($urandom));
            end
            if (left_b == 0 || (left_a > 0 && $urandom_range(1) == 1))
            begin
                send_request(OP_LOAD_A, pick_char(narrow));
                left_a--;
            end
            else
            begin
                send_request(OP_LOAD_B, pick_char(narrow));
                left_b--;
            end
        end
        send_request(OP_COMPUTE, 8'($urandom));
    endtask

    task automatic test_empty_strings();
        send_request(OP_COMPUTE, 8'h00);
        send_request(OP_LOAD_A, 8'h00);
        send_request(OP_LOAD_A, 8'hFF);
        send_request(OP_COMPUTE, 8'hFF);
        send_request(OP_LOAD_B, 8'h55);
        send_request(OP_LOAD_B, 8'hAA);
        send_request(OP_COMPUTE, 8'h00);
    endtask

    task automatic test_unused_op();
        send_request(OP_LOAD_A, 8'h78);
        send_request(OP_UNUSED, 8'hFF);
        send_request(OP_UNUSED, 8'h00);
        send_request(OP_LOAD_B, 8'h78);
        send_request(OP_UNUSED, 8'h41);
        send_request(OP_COMPUTE, 8'h00);
    endtask

    // '@' '[' and '`' '{' sit just outside the letter ranges and must not fold
    task automatic test_case_folding();
        logic [7:0] upper [4];
        logic [7:0] lower [4];
        upper = '{8'h41, 8'h5A, 8'h40, 8'h5B};
        lower = '{8'h61, 8'h7A, 8'h60, 8'h7B};
        for (int mode = 1; mode >= 0; mode--)
        begin
            write_case_mode(1'(mode));
            for (int k = 0; k < 4; k++)
            begin
                send_request(OP_LOAD_A, upper[k]);
                send_request(OP_LOAD_B, lower[k]);
            end
            send_request(OP_COMPUTE, 8'h00);
        end
    endtask

    task automatic test_result_backpressure();
        hold_request = 300;
        repeat (5) send_string_pair(2, 3, 1'b1);
        // sender stops until every result has drained
        wait_for_idle();
    endtask

    task automatic test_capacity();
        write_case_mode(1'b1);
        send_string_pair(MAX_LEN, MAX_LEN, 1'b0);
        send_string_pair(MAX_LEN + 6, 3, 1'b1);
        send_string_pair(0, MAX_LEN + 2, 1'b0);
        write_case_mode(1'b0);
        send_string_pair(MAX_LEN, 0, 1'b1);
        send_string_pair(MAX_LEN + 1, MAX_LEN + 1, 1'b1);
    endtask

    task automatic test_random_mix();
        int goal;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            write_case_mode(1'(p % 2));
            no_idle = (p == 3);
            goal    = ITEM_TARGET * (p + 1) / RAND_PHASES;
            while (items_sent < goal)
            begin
                send_string_pair(pick_length(), pick_length(), 1'($urandom_range(1)));
            end
        end
        no_idle = 1'b0;
    endtask

    // result side: random stall plus a long hold-off on request
    initial
    begin : receiver
        int held;
        held = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                held         = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                out_stall <= 1'b1;
                held--;
            end
            else
            begin
                out_stall <= !no_idle && $urandom_range(99) < 14;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        distance_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_distances.size() == 0)
            begin
                report_mismatch("result with nothing pending, distance", distance, 0);
            end
            else
            begin
                want = pending_distances.pop_front();
                if (distance !== want.distance)
                begin
                    report_mismatch("distance", distance, want.distance);
                end
                if (truncated !== want.truncated)
                begin
                    report_mismatch("truncated", truncated, want.truncated);
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_strings();
        test_unused_op();
        test_case_folding();
        test_result_backpressure();
        test_capacity();
        test_random_mix();
        wait_for_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
